### sv/sti_pkg.sv
`timescale 1ns / 1ps
package sti_pkg;

    // Coordinate and derived widths; all products are kept exact
    localparam int CW        = 32;
    localparam int DIF_W     = CW + 1;
    localparam int PRD_W     = 2 * DIF_W;
    localparam int CRS_W     = PRD_W + 1;
    localparam int LO_W      = 34;
    localparam int HI_W      = CRS_W - LO_W;
    localparam int LO_PRD_W  = DIF_W + LO_W + 1;
    localparam int HI_PRD_W  = DIF_W + HI_W;
    localparam int DW        = 104;
    localparam int NPRD      = 12;

    // Parameter result format
    localparam int PFB       = 16;
    localparam int QW        = PFB + 1;

    // Register file
    localparam int NREG      = 6;
    localparam int AW        = 5;
    localparam int DATA_W    = 32;
    localparam int IDX_W     = 3;

    typedef enum logic [IDX_W-1:0] {
        REG_START_X = 3'd0,
        REG_START_Y = 3'd1,
        REG_START_Z = 3'd2,
        REG_END_X   = 3'd3,
        REG_END_Y   = 3'd4,
        REG_END_Z   = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } cvec_t;

    typedef struct packed {
        logic signed [DIF_W-1:0] x;
        logic signed [DIF_W-1:0] y;
        logic signed [DIF_W-1:0] z;
    } dvec_t;

    typedef struct packed {
        logic signed [CRS_W-1:0] x;
        logic signed [CRS_W-1:0] y;
        logic signed [CRS_W-1:0] z;
    } xvec_t;

    // Raw dot products; wn already negated
    typedef struct packed {
        logic signed [DW-1:0] d;
        logic signed [DW-1:0] tn;
        logic signed [DW-1:0] vn;
        logic signed [DW-1:0] wn;
    } dot_res_t;

    // Bounds test outcome handed to the divider
    typedef struct packed {
        logic          miss;
        logic [DW-1:0] tn;
        logic [DW-1:0] d;
    } test_res_t;

    function automatic dvec_t vsub(cvec_t a, cvec_t b);
        dvec_t r;
        r.x = DIF_W'($signed(a.x)) - DIF_W'($signed(b.x));
        r.y = DIF_W'($signed(a.y)) - DIF_W'($signed(b.y));
        r.z = DIF_W'($signed(a.z)) - DIF_W'($signed(b.z));
        return r;
    endfunction

endpackage

### sv/sti_front.sv
`timescale 1ns / 1ps
// Edge vectors, cross product partials, cross products (3 stages)
module sti_front
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  sti_pkg::cvec_t   va,
    input  sti_pkg::cvec_t   vb,
    input  sti_pkg::cvec_t   vc,
    input  sti_pkg::cvec_t   vp,
    input  sti_pkg::dvec_t   qp,
    output logic             out_valid,
    output sti_pkg::dvec_t   ab,
    output sti_pkg::dvec_t   ac,
    output sti_pkg::dvec_t   ap,
    output sti_pkg::xvec_t   nrm,
    output sti_pkg::xvec_t   ev
);

    logic                            v1_reg, v2_reg, v3_reg;
    sti_pkg::dvec_t                  ab1_reg, ac1_reg, ap1_reg;
    sti_pkg::dvec_t                  ab1_next, ac1_next, ap1_next;
    sti_pkg::dvec_t                  ab2_reg, ac2_reg, ap2_reg;
    sti_pkg::dvec_t                  ab3_reg, ac3_reg, ap3_reg;
    logic signed [sti_pkg::PRD_W-1:0] pn_reg [6];
    logic signed [sti_pkg::PRD_W-1:0] pe_reg [6];
    logic signed [sti_pkg::PRD_W-1:0] pn_next [6];
    logic signed [sti_pkg::PRD_W-1:0] pe_next [6];
    sti_pkg::xvec_t                  n3_reg, e3_reg, n3_next, e3_next;

    assign ab1_next = sti_pkg::vsub(vb, va);
    assign ac1_next = sti_pkg::vsub(vc, va);
    assign ap1_next = sti_pkg::vsub(vp, va);

    always_comb
    begin
        pn_next[0] = sti_pkg::PRD_W'($signed(ab1_reg.y)) * sti_pkg::PRD_W'($signed(ac1_reg.z));
        pn_next[1] = sti_pkg::PRD_W'($signed(ab1_reg.z)) * sti_pkg::PRD_W'($signed(ac1_reg.y));
        pn_next[2] = sti_pkg::PRD_W'($signed(ab1_reg.z)) * sti_pkg::PRD_W'($signed(ac1_reg.x));
        pn_next[3] = sti_pkg::PRD_W'($signed(ab1_reg.x)) * sti_pkg::PRD_W'($signed(ac1_reg.z));
        pn_next[4] = sti_pkg::PRD_W'($signed(ab1_reg.x)) * sti_pkg::PRD_W'($signed(ac1_reg.y));
        pn_next[5] = sti_pkg::PRD_W'($signed(ab1_reg.y)) * sti_pkg::PRD_W'($signed(ac1_reg.x));
        pe_next[0] = sti_pkg::PRD_W'($signed(qp.y)) * sti_pkg::PRD_W'($signed(ap1_reg.z));
        pe_next[1] = sti_pkg::PRD_W'($signed(qp.z)) * sti_pkg::PRD_W'($signed(ap1_reg.y));
        pe_next[2] = sti_pkg::PRD_W'($signed(qp.z)) * sti_pkg::PRD_W'($signed(ap1_reg.x));
        pe_next[3] = sti_pkg::PRD_W'($signed(qp.x)) * sti_pkg::PRD_W'($signed(ap1_reg.z));
        pe_next[4] = sti_pkg::PRD_W'($signed(qp.x)) * sti_pkg::PRD_W'($signed(ap1_reg.y));
        pe_next[5] = sti_pkg::PRD_W'($signed(qp.y)) * sti_pkg::PRD_W'($signed(ap1_reg.x));
    end

    always_comb
    begin
        n3_next.x = sti_pkg::CRS_W'(pn_reg[0]) - sti_pkg::CRS_W'(pn_reg[1]);
        n3_next.y = sti_pkg::CRS_W'(pn_reg[2]) - sti_pkg::CRS_W'(pn_reg[3]);
        n3_next.z = sti_pkg::CRS_W'(pn_reg[4]) - sti_pkg::CRS_W'(pn_reg[5]);
        e3_next.x = sti_pkg::CRS_W'(pe_reg[0]) - sti_pkg::CRS_W'(pe_reg[1]);
        e3_next.y = sti_pkg::CRS_W'(pe_reg[2]) - sti_pkg::CRS_W'(pe_reg[3]);
        e3_next.z = sti_pkg::CRS_W'(pe_reg[4]) - sti_pkg::CRS_W'(pe_reg[5]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ab1_reg <= ab1_next;
            ac1_reg <= ac1_next;
            ap1_reg <= ap1_next;
            for (int k = 0; k < 6; k++)
            begin
                pn_reg[k] <= pn_next[k];
                pe_reg[k] <= pe_next[k];
            end
            ab2_reg <= ab1_reg;
            ac2_reg <= ac1_reg;
            ap2_reg <= ap1_reg;
            n3_reg  <= n3_next;
            e3_reg  <= e3_next;
            ab3_reg <= ab2_reg;
            ac3_reg <= ac2_reg;
            ap3_reg <= ap2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign ab        = ab3_reg;
    assign ac        = ac3_reg;
    assign ap        = ap3_reg;
    assign nrm       = n3_reg;
    assign ev        = e3_reg;

endmodule

### sv/sti_dot.sv
`timescale 1ns / 1ps
// Dot products d, tn, vn, wn: split partials, recombine, sum (3 stages)
module sti_dot
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  sti_pkg::dvec_t    qp,
    input  sti_pkg::dvec_t    ab,
    input  sti_pkg::dvec_t    ac,
    input  sti_pkg::dvec_t    ap,
    input  sti_pkg::xvec_t    nrm,
    input  sti_pkg::xvec_t    ev,
    output logic              out_valid,
    output sti_pkg::dot_res_t res
);

    logic signed [sti_pkg::DIF_W-1:0]    xa [sti_pkg::NPRD];
    logic signed [sti_pkg::CRS_W-1:0]    xb [sti_pkg::NPRD];
    logic signed [sti_pkg::LO_PRD_W-1:0] plo_reg [sti_pkg::NPRD];
    logic signed [sti_pkg::LO_PRD_W-1:0] plo_next [sti_pkg::NPRD];
    logic signed [sti_pkg::HI_PRD_W-1:0] phi_reg [sti_pkg::NPRD];
    logic signed [sti_pkg::HI_PRD_W-1:0] phi_next [sti_pkg::NPRD];
    logic signed [sti_pkg::DW-1:0]       prd_reg [sti_pkg::NPRD];
    logic signed [sti_pkg::DW-1:0]       prd_next [sti_pkg::NPRD];
    sti_pkg::dot_res_t                   res_reg, res_next;
    logic                                v1_reg, v2_reg, v3_reg;

    // operand pairs: d = qp.n, tn = ap.n, vn = ac.e, wn = -(ab.e)
    always_comb
    begin
        xa[0]  = qp.x; xa[1]  = qp.y; xa[2]  = qp.z;
        xa[3]  = ap.x; xa[4]  = ap.y; xa[5]  = ap.z;
        xa[6]  = ac.x; xa[7]  = ac.y; xa[8]  = ac.z;
        xa[9]  = ab.x; xa[10] = ab.y; xa[11] = ab.z;
        xb[0]  = nrm.x; xb[1]  = nrm.y; xb[2]  = nrm.z;
        xb[3]  = nrm.x; xb[4]  = nrm.y; xb[5]  = nrm.z;
        xb[6]  = ev.x;  xb[7]  = ev.y;  xb[8]  = ev.z;
        xb[9]  = ev.x;  xb[10] = ev.y;  xb[11] = ev.z;
    end

    // low limb unsigned, high limb signed
    always_comb
    begin
        for (int k = 0; k < sti_pkg::NPRD; k++)
        begin
            plo_next[k] = sti_pkg::LO_PRD_W'(xa[k])
                        * sti_pkg::LO_PRD_W'($signed({1'b0, xb[k][sti_pkg::LO_W-1:0]}));
            phi_next[k] = sti_pkg::HI_PRD_W'(xa[k])
                        * sti_pkg::HI_PRD_W'($signed(xb[k][sti_pkg::CRS_W-1:sti_pkg::LO_W]));
            prd_next[k] = (sti_pkg::DW'(phi_reg[k]) <<< sti_pkg::LO_W)
                        + sti_pkg::DW'(plo_reg[k]);
        end
    end

    always_comb
    begin
        res_next.d  = prd_reg[0] + prd_reg[1] + prd_reg[2];
        res_next.tn = prd_reg[3] + prd_reg[4] + prd_reg[5];
        res_next.vn = prd_reg[6] + prd_reg[7] + prd_reg[8];
        res_next.wn = -(prd_reg[9] + prd_reg[10] + prd_reg[11]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < sti_pkg::NPRD; k++)
            begin
                plo_reg[k] <= plo_next[k];
                phi_reg[k] <= phi_next[k];
                prd_reg[k] <= prd_next[k];
            end
            res_reg <= res_next;
        end
    end

    assign out_valid = v3_reg;
    assign res       = res_reg;

endmodule

### sv/sti_test.sv
`timescale 1ns / 1ps
// Sign normalisation and bounds tests (2 stages)
module sti_test
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  sti_pkg::dot_res_t  dot,
    output logic               out_valid,
    output sti_pkg::test_res_t res
);

    sti_pkg::dot_res_t  nrm_reg, nrm_next;
    logic               zero_reg, zero_next;
    sti_pkg::test_res_t res_reg, res_next;
    logic               v1_reg, v2_reg;
    logic signed [sti_pkg::DW-1:0] vw_sum;

    always_comb
    begin
        zero_next = (dot.d == '0);
        if (dot.d < 0)
        begin
            nrm_next.d  = -dot.d;
            nrm_next.tn = -dot.tn;
            nrm_next.vn = -dot.vn;
            nrm_next.wn = -dot.wn;
        end
        else
        begin
            nrm_next = dot;
        end
    end

    assign vw_sum = nrm_reg.vn + nrm_reg.wn;

    always_comb
    begin
        res_next.miss = zero_reg
                      || (nrm_reg.tn < 0) || (nrm_reg.d < nrm_reg.tn)
                      || (nrm_reg.vn < 0) || (nrm_reg.d < nrm_reg.vn)
                      || (nrm_reg.wn < 0) || (nrm_reg.d < vw_sum);
        res_next.tn   = nrm_reg.tn;
        res_next.d    = nrm_reg.d;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nrm_reg  <= nrm_next;
            zero_reg <= zero_next;
            res_reg  <= res_next;
        end
    end

    assign out_valid = v2_reg;
    assign res       = res_reg;

endmodule

### sv/sti_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit a stage: floor(tn * 2^PFB / d)
module sti_div
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  sti_pkg::test_res_t      src,
    output logic                    out_valid,
    output logic                    hit,
    output logic [sti_pkg::QW-1:0]  hit_param
);

    localparam int STG = sti_pkg::QW;

    logic [STG-1:0]            v_reg, miss_reg;
    logic [STG-1:0]            v_in, miss_in, ge;
    logic [sti_pkg::DW-1:0]    r_reg [STG];
    logic [sti_pkg::DW-1:0]    d_reg [STG];
    logic [sti_pkg::DW-1:0]    r_in [STG];
    logic [sti_pkg::DW-1:0]    d_in [STG];
    logic [sti_pkg::DW-1:0]    r_next [STG];
    logic [sti_pkg::QW-1:0]    q_reg [STG];
    logic [sti_pkg::QW-1:0]    q_in [STG];
    logic [sti_pkg::QW-1:0]    q_next [STG];

    for (genvar k = 0; k < STG; k++)
    begin : g_step
        if (k == 0)
        begin : g_first
            assign r_in[k]    = src.tn;
            assign d_in[k]    = src.d;
            assign q_in[k]    = '0;
            assign v_in[k]    = in_valid;
            assign miss_in[k] = src.miss;
        end
        else
        begin : g_rest
            assign r_in[k]    = {r_reg[k-1][sti_pkg::DW-2:0], 1'b0};
            assign d_in[k]    = d_reg[k-1];
            assign q_in[k]    = q_reg[k-1];
            assign v_in[k]    = v_reg[k-1];
            assign miss_in[k] = miss_reg[k-1];
        end

        assign ge[k]     = (r_in[k] >= d_in[k]);
        assign r_next[k] = ge[k] ? (r_in[k] - d_in[k]) : r_in[k];
        assign q_next[k] = {q_in[k][sti_pkg::QW-2:0], ge[k]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= v_in[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[k]    <= r_next[k];
                d_reg[k]    <= d_in[k];
                q_reg[k]    <= q_next[k];
                miss_reg[k] <= miss_in[k];
            end
        end
    end

    assign out_valid = v_reg[STG-1];
    assign hit       = !miss_reg[STG-1];
    assign hit_param = miss_reg[STG-1] ? '0 : q_reg[STG-1];

    // remainder always below the divisor on a hit
    a_rem_below_d: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[STG-1] && !miss_reg[STG-1]) |-> (r_reg[STG-1] < d_reg[STG-1]))
        else $error("divider remainder not below divisor");

    // a hit never carries a zero divisor
    a_hit_nonzero_d: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[STG-1] && !miss_reg[STG-1]) |-> (d_reg[STG-1] != '0))
        else $error("hit with zero denominator");

    // t never exceeds 1.0
    a_param_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (hit_param <= sti_pkg::QW'(1 << sti_pkg::PFB)))
        else $error("hit_param above 1.0");

    // first stage quotient bit only set when tn equals d
    a_first_bit: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[0] && !miss_reg[0] && q_reg[0][0]) |-> (r_reg[0] == '0))
        else $error("first quotient bit with nonzero remainder");

endmodule

### sv/segment_triangle_intersect.sv
`timescale 1ns / 1ps
// Segment / triangle intersection engine.
// The segment end points P (start_*) and Q (end_*) sit in six 32-bit APB
// registers at byte offsets 0x00..0x14; write them while the engine is idle.
// Each input item is one triangle A, B, C (signed Q16.16) on a valid/ready
// channel; each produces exactly one result item: hit, and hit_param = t in
// unsigned Q1.16 (0x10000 = 1.0, truncated), 0 on a miss.
// Throughput: one triangle per clock unless the output stalls. From acceptance to
// out_valid there are 3 stages of edge vectors and cross products, 3 of split dot
// products, 2 of sign normalisation and bounds tests and 17 divider stages (one
// quotient bit each), the last of which is the output register.
// The pipeline moves as a whole: when out_valid is high and out_ready low,
// every stage holds and in_ready drops in the same cycle; nothing is lost or
// repeated. A result waiting at the output stops new items entering even
// when earlier stages hold bubbles; in_ready is high while out_valid is low or out_ready high.
// Reset (rst_n low, asynchronous) clears all valid bits and the configuration registers.
module segment_triangle_intersect
(
    input  logic                        clk,
    input  logic                        rst_n,
    // APB configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sti_pkg::AW-1:0]      paddr,
    input  logic [sti_pkg::DATA_W-1:0]  pwdata,
    output logic [sti_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    // triangle input
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic signed [31:0]          vert_a_x,
    input  logic signed [31:0]          vert_a_y,
    input  logic signed [31:0]          vert_a_z,
    input  logic signed [31:0]          vert_b_x,
    input  logic signed [31:0]          vert_b_y,
    input  logic signed [31:0]          vert_b_z,
    input  logic signed [31:0]          vert_c_x,
    input  logic signed [31:0]          vert_c_y,
    input  logic signed [31:0]          vert_c_z,
    // result output
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        hit,
    output logic [sti_pkg::QW-1:0]      hit_param
);

    logic signed [sti_pkg::CW-1:0] cfg_reg [sti_pkg::NREG];
    sti_pkg::reg_idx_t             widx;
    logic                          wr_en, en;

    sti_pkg::cvec_t    va, vb, vc, vp, vq;
    sti_pkg::dvec_t    qp, ab, ac, ap;
    sti_pkg::xvec_t    nrm, ev;
    sti_pkg::dot_res_t dot_res;
    sti_pkg::test_res_t tst_res;
    logic              fr_valid, dot_valid, tst_valid;

    // ---------------- register port ----------------
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign widx   = sti_pkg::reg_idx_t'(paddr[sti_pkg::AW-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < sti_pkg::NREG; k++)
            begin
                cfg_reg[k] <= '0;
            end
        end
        else if (wr_en)
        begin
            unique case (widx)
                sti_pkg::REG_START_X: cfg_reg[sti_pkg::REG_START_X] <= pwdata;
                sti_pkg::REG_START_Y: cfg_reg[sti_pkg::REG_START_Y] <= pwdata;
                sti_pkg::REG_START_Z: cfg_reg[sti_pkg::REG_START_Z] <= pwdata;
                sti_pkg::REG_END_X:   cfg_reg[sti_pkg::REG_END_X]   <= pwdata;
                sti_pkg::REG_END_Y:   cfg_reg[sti_pkg::REG_END_Y]   <= pwdata;
                sti_pkg::REG_END_Z:   cfg_reg[sti_pkg::REG_END_Z]   <= pwdata;
                default: ;  // unmapped offsets ignored
            endcase
        end
    end

    always_comb
    begin
        unique case (widx)
            sti_pkg::REG_START_X: prdata = cfg_reg[sti_pkg::REG_START_X];
            sti_pkg::REG_START_Y: prdata = cfg_reg[sti_pkg::REG_START_Y];
            sti_pkg::REG_START_Z: prdata = cfg_reg[sti_pkg::REG_START_Z];
            sti_pkg::REG_END_X:   prdata = cfg_reg[sti_pkg::REG_END_X];
            sti_pkg::REG_END_Y:   prdata = cfg_reg[sti_pkg::REG_END_Y];
            sti_pkg::REG_END_Z:   prdata = cfg_reg[sti_pkg::REG_END_Z];
            default:              prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    // whole pipe advances unless a result sits unaccepted at the output
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    assign va = '{x: vert_a_x, y: vert_a_y, z: vert_a_z};
    assign vb = '{x: vert_b_x, y: vert_b_y, z: vert_b_z};
    assign vc = '{x: vert_c_x, y: vert_c_y, z: vert_c_z};
    assign vp = '{x: cfg_reg[sti_pkg::REG_START_X], y: cfg_reg[sti_pkg::REG_START_Y],
                  z: cfg_reg[sti_pkg::REG_START_Z]};
    assign vq = '{x: cfg_reg[sti_pkg::REG_END_X], y: cfg_reg[sti_pkg::REG_END_Y],
                  z: cfg_reg[sti_pkg::REG_END_Z]};

    // P - Q only changes with configuration, so it is held combinationally
    assign qp = sti_pkg::vsub(vp, vq);

    sti_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .va        (va),
        .vb        (vb),
        .vc        (vc),
        .vp        (vp),
        .qp        (qp),
        .out_valid (fr_valid),
        .ab        (ab),
        .ac        (ac),
        .ap        (ap),
        .nrm       (nrm),
        .ev        (ev)
    );

    sti_dot u_dot
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (fr_valid),
        .qp        (qp),
        .ab        (ab),
        .ac        (ac),
        .ap        (ap),
        .nrm       (nrm),
        .ev        (ev),
        .out_valid (dot_valid),
        .res       (dot_res)
    );

    sti_test u_test
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (dot_valid),
        .dot       (dot_res),
        .out_valid (tst_valid),
        .res       (tst_res)
    );

    sti_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (tst_valid),
        .src       (tst_res),
        .out_valid (out_valid),
        .hit       (hit),
        .hit_param (hit_param)
    );

endmodule
